>>> rtl/frame_rate_meter_defines.svh
// assertion macros used by the frame rate meter top level
`ifndef FRAME_RATE_METER_DEFINES_SVH
`define FRAME_RATE_METER_DEFINES_SVH

// antecedent implies consequent in the same cycle, sampled on clk, off during reset
`define FRM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the following cycle
`define FRM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/frm_pkg.sv
// shared types, constants and widths of the frame rate meter
package frm_pkg;

    localparam int DELTA_W    = 20;
    localparam int WIN_W      = 20;
    localparam int HCNT_W     = 7;
    localparam int CNT_W      = 20;
    localparam int ACC_W      = 21;
    localparam int RATE_W     = 24;
    localparam int US_W       = 20;
    localparam int PROD_W     = CNT_W + US_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 20;

    localparam int HISTORY_DEPTH_DEF  = 64;
    localparam int RATE_FRAC_BITS_DEF = 8;

    localparam logic [US_W-1:0]   US_PER_SECOND = US_W'(1000000);
    localparam logic [CNT_W-1:0]  CNT_MAX       = '1;
    localparam logic [RATE_W-1:0] RATE_MAX      = '1;
    localparam logic [WIN_W-1:0]  WIN_RESET     = WIN_W'(33333);
    localparam logic [HCNT_W-1:0] HCNT_RESET    = HCNT_W'(60);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_US,
        CFG_HISTORY_COUNT
    } cfg_idx_t;

    typedef enum logic {
        DIV_SEL_RATE,
        DIV_SEL_MEAN
    } div_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_RATE_GO,
        ST_RATE_WAIT,
        ST_PUSH,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_DELIVER
    } state_t;

    typedef struct packed {
        logic     accum;
        logic     mul;
        logic     div_start;
        div_sel_t div_sel;
        logic     push;
        logic     load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic window_closed;
        logic div_busy;
    } ctrl_sts_t;

endpackage

>>> rtl/frm_if.sv
// channel interfaces: frame time input, rate result output, register write

interface frm_in_if;
    logic                          valid;
    logic                          ready;
    logic [frm_pkg::DELTA_W-1:0]   frame_delta_us;

    modport source (output valid, output frame_delta_us, input ready);
    modport sink   (input valid, input frame_delta_us, output ready);
endinterface

interface frm_out_if;
    logic                        valid;
    logic                        ready;
    logic [frm_pkg::RATE_W-1:0]  current_rate;
    logic [frm_pkg::RATE_W-1:0]  min_rate;
    logic [frm_pkg::RATE_W-1:0]  max_rate;
    logic [frm_pkg::RATE_W-1:0]  mean_rate;

    modport source (output valid, output current_rate, output min_rate,
                    output max_rate, output mean_rate, input ready);
    modport sink   (input valid, input current_rate, input min_rate,
                    input max_rate, input mean_rate, output ready);
endinterface

interface frm_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [frm_pkg::CFG_IDX_W-1:0]   index;
    logic [frm_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/frm_divider.sv
// restoring divider, one quotient bit per cycle, shared by rate and mean
module frm_divider #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 21
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [$clog2(NUM_W+1)-1:0]    iters,
    input  logic [NUM_W-1:0]              num,
    input  logic [DEN_W-1:0]              den,
    output logic                          busy,
    output logic [NUM_W-1:0]              quot
);

    localparam int ITER_W = $clog2(NUM_W + 1);

    logic [ITER_W-1:0] count_reg;
    logic [NUM_W-1:0]  q_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;

    logic [DEN_W:0]    rem_shift;
    logic [DEN_W:0]    diff;
    logic              fits;

    always_comb
    begin
        rem_shift = {rem_reg, q_reg[NUM_W-1]};
        diff      = rem_shift - {1'b0, den_reg};
        fits      = (rem_shift >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (start)
        begin
            count_reg <= iters;
        end
        else if (count_reg != '0)
        begin
            count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (count_reg != '0)
        begin
            q_reg   <= {q_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
        end
    end

    assign busy = (count_reg != '0);
    assign quot = q_reg;

endmodule

>>> rtl/frm_ctrl.sv
// sequencer of the frame rate meter
module frm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  frm_pkg::ctrl_sts_t   sts,
    output frm_pkg::ctrl_cmd_t   cmd
);

    frm_pkg::state_t state_reg;
    frm_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            frm_pkg::ST_IDLE:      if (in_valid) state_next = frm_pkg::ST_CHECK;
            frm_pkg::ST_CHECK:     state_next = sts.window_closed ? frm_pkg::ST_MUL
                                                                  : frm_pkg::ST_IDLE;
            frm_pkg::ST_MUL:       state_next = frm_pkg::ST_RATE_GO;
            frm_pkg::ST_RATE_GO:   state_next = frm_pkg::ST_RATE_WAIT;
            frm_pkg::ST_RATE_WAIT: if (!sts.div_busy) state_next = frm_pkg::ST_PUSH;
            frm_pkg::ST_PUSH:      state_next = frm_pkg::ST_MEAN_GO;
            frm_pkg::ST_MEAN_GO:   state_next = frm_pkg::ST_MEAN_WAIT;
            frm_pkg::ST_MEAN_WAIT: if (!sts.div_busy) state_next = frm_pkg::ST_DELIVER;
            frm_pkg::ST_DELIVER:   if (slot_free) state_next = frm_pkg::ST_IDLE;
            default:               state_next = frm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.div_sel  = frm_pkg::DIV_SEL_RATE;
        in_ready     = 1'b0;
        unique case (state_reg)
            frm_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.accum = in_valid;
            end
            frm_pkg::ST_MUL:     cmd.mul = 1'b1;
            frm_pkg::ST_RATE_GO: cmd.div_start = 1'b1;
            frm_pkg::ST_PUSH:    cmd.push = 1'b1;
            frm_pkg::ST_MEAN_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = frm_pkg::DIV_SEL_MEAN;
            end
            frm_pkg::ST_DELIVER: cmd.load_out = slot_free;
            default:             cmd = '0;
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= frm_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> rtl/frm_datapath.sv
// window counters, rate history ring, running sum, min and max, result register
module frm_datapath #(
    parameter int HISTORY_DEPTH  = frm_pkg::HISTORY_DEPTH_DEF,
    parameter int RATE_FRAC_BITS = frm_pkg::RATE_FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  frm_pkg::ctrl_cmd_t                cmd,
    output frm_pkg::ctrl_sts_t                sts,
    input  logic [frm_pkg::DELTA_W-1:0]       frame_delta_us,
    input  logic                              cfg_we,
    input  logic [frm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [frm_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic [frm_pkg::RATE_W-1:0]        current_rate,
    output logic [frm_pkg::RATE_W-1:0]        min_rate,
    output logic [frm_pkg::RATE_W-1:0]        max_rate,
    output logic [frm_pkg::RATE_W-1:0]        mean_rate
);

    localparam int RATE_W     = frm_pkg::RATE_W;
    localparam int ACC_W      = frm_pkg::ACC_W;
    localparam int CNT_W      = frm_pkg::CNT_W;
    localparam int HCNT_W     = frm_pkg::HCNT_W;
    localparam int PROD_W     = frm_pkg::PROD_W;
    localparam int HELD_W     = $clog2(HISTORY_DEPTH + 1);
    localparam int SLOT_W     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int SUM_W      = RATE_W + $clog2(HISTORY_DEPTH);
    localparam int OLD_W      = $clog2(2 * HISTORY_DEPTH);
    localparam int CMP_W      = (HCNT_W > HELD_W) ? HCNT_W : HELD_W;
    localparam int RNUM_W     = PROD_W + RATE_FRAC_BITS;
    localparam int NUM_W      = (RNUM_W > SUM_W) ? RNUM_W : SUM_W;
    localparam int DEN_W      = (ACC_W > HELD_W) ? ACC_W : HELD_W;
    localparam int ITER_W     = $clog2(NUM_W + 1);

    // configuration
    logic [frm_pkg::WIN_W-1:0] window_us_reg;
    logic [HCNT_W-1:0]         history_count_reg;

    // window and history state
    logic [CNT_W-1:0]  frames_reg, frames_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [HELD_W-1:0] held_reg, held_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [RATE_W-1:0] low_reg, high_reg;

    // payload
    logic [PROD_W-1:0] prod_reg;
    logic [ACC_W-1:0]  den_reg;
    logic [RATE_W-1:0] oldest_reg;
    logic [RATE_W-1:0] rate_reg;
    logic [RATE_W-1:0] cur_out_reg, min_out_reg, max_out_reg, mean_out_reg;
    logic [RATE_W-1:0] hist_mem [HISTORY_DEPTH];

    logic [CMP_W-1:0]  hc_ext;
    logic [HELD_W-1:0] limit;
    logic              drop;
    logic [OLD_W-1:0]  old_raw;
    logic [OLD_W-1:0]  old_idx;
    logic [RATE_W-1:0] rate_sat;

    logic              div_busy;
    logic [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;
    logic [ITER_W-1:0] div_iters;
    logic [NUM_W-1:0]  div_quot;

    // history limit, clamped to one .. depth
    always_comb
    begin
        hc_ext = CMP_W'(history_count_reg);
        if (hc_ext == '0)
        begin
            limit = HELD_W'(1);
        end
        else if (hc_ext > CMP_W'(HISTORY_DEPTH))
        begin
            limit = HELD_W'(HISTORY_DEPTH);
        end
        else
        begin
            limit = HELD_W'(hc_ext);
        end
        drop = (held_reg >= limit);
    end

    // oldest held slot, modulo depth
    always_comb
    begin
        old_raw = OLD_W'(slot_reg) + OLD_W'(HISTORY_DEPTH) - OLD_W'(held_reg);
        if (old_raw >= OLD_W'(HISTORY_DEPTH))
        begin
            old_idx = old_raw - OLD_W'(HISTORY_DEPTH);
        end
        else
        begin
            old_idx = old_raw;
        end
    end

    assign rate_sat = (div_quot[NUM_W-1:RATE_W] != '0) ? frm_pkg::RATE_MAX
                                                       : div_quot[RATE_W-1:0];

    // divider operands; the mean numerator is left-aligned so it needs fewer steps
    always_comb
    begin
        if (cmd.div_sel == frm_pkg::DIV_SEL_RATE)
        begin
            div_num   = NUM_W'(prod_reg) << RATE_FRAC_BITS;
            div_den   = DEN_W'(den_reg);
            div_iters = ITER_W'(NUM_W);
        end
        else
        begin
            div_num   = NUM_W'(sum_reg) << (NUM_W - SUM_W);
            div_den   = DEN_W'(held_reg);
            div_iters = ITER_W'(SUM_W);
        end
    end

    frm_divider #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .iters (div_iters),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    always_comb
    begin
        frames_next = frames_reg;
        acc_next    = acc_reg;
        if (cmd.accum)
        begin
            if (frames_reg != frm_pkg::CNT_MAX)
            begin
                frames_next = frames_reg + 1'b1;
            end
            acc_next = acc_reg + ACC_W'(frame_delta_us);
        end
        else if (cmd.mul)
        begin
            frames_next = '0;
            acc_next    = '0;
        end
    end

    always_comb
    begin
        held_next = held_reg;
        slot_next = slot_reg;
        sum_next  = sum_reg;
        if (cmd.push)
        begin
            sum_next  = sum_reg - (drop ? SUM_W'(oldest_reg) : SUM_W'(0)) + SUM_W'(rate_sat);
            held_next = drop ? held_reg : held_reg + 1'b1;
            slot_next = (slot_reg == SLOT_W'(HISTORY_DEPTH - 1)) ? SLOT_W'(0)
                                                                 : slot_reg + 1'b1;
        end
        if (cfg_we && (cfg_index == frm_pkg::CFG_HISTORY_COUNT))
        begin
            held_next = '0;
            slot_next = '0;
            sum_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_us_reg     <= frm_pkg::WIN_RESET;
            history_count_reg <= frm_pkg::HCNT_RESET;
            frames_reg        <= '0;
            acc_reg           <= '0;
            held_reg          <= '0;
            slot_reg          <= '0;
            sum_reg           <= '0;
            low_reg           <= frm_pkg::RATE_MAX;
            high_reg          <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    frm_pkg::CFG_WINDOW_US:     window_us_reg <= cfg_data;
                    frm_pkg::CFG_HISTORY_COUNT: history_count_reg <= cfg_data[HCNT_W-1:0];
                    default:                    window_us_reg <= window_us_reg;
                endcase
            end
            frames_reg <= frames_next;
            acc_reg    <= acc_next;
            held_reg   <= held_next;
            slot_reg   <= slot_next;
            sum_reg    <= sum_next;
            if (cmd.push)
            begin
                if (rate_sat < low_reg)
                begin
                    low_reg <= rate_sat;
                end
                if (rate_sat > high_reg)
                begin
                    high_reg <= rate_sat;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg   <= frames_reg * frm_pkg::US_PER_SECOND;
            den_reg    <= acc_reg;
            oldest_reg <= hist_mem[SLOT_W'(old_idx)];
        end
        if (cmd.push)
        begin
            hist_mem[slot_reg] <= rate_sat;
            rate_reg           <= rate_sat;
        end
        if (cmd.load_out)
        begin
            cur_out_reg  <= rate_reg;
            min_out_reg  <= low_reg;
            max_out_reg  <= high_reg;
            mean_out_reg <= div_quot[RATE_W-1:0];
        end
    end

    assign sts.window_closed = (acc_reg >= ACC_W'(window_us_reg));
    assign sts.div_busy      = div_busy;

    assign current_rate = cur_out_reg;
    assign min_rate     = min_out_reg;
    assign max_rate     = max_out_reg;
    assign mean_rate    = mean_out_reg;

endmodule

>>> rtl/frame_rate_meter.sv
// top level of the frame rate meter: sequencer, datapath and channel glue
//
//  channel  dir  payload                                         handshake
//  frame    in   frame_delta_us[19:0]                            valid / ready
//  result   out  current_rate, min_rate, max_rate, mean_rate     valid / ready
//  cfg      in   index[0], data[19:0]                            valid / ready
//
//  an item that closes no window is accepted and then compared with the window
//  an item that closes a window then goes on through multiply, rate quotient,
//  history push, history mean and delivery; the shared one-bit-per-cycle
//  divider computes the rate quotient, then the history mean
//  a finished result sits in the output register; the next item is taken while
//  it waits, and only the delivery step stalls until that register is free
//  reset is asynchronous, active low; the history memory is not cleared
`include "frame_rate_meter_defines.svh"

module frame_rate_meter #(
    parameter int HISTORY_DEPTH  = frm_pkg::HISTORY_DEPTH_DEF,
    parameter int RATE_FRAC_BITS = frm_pkg::RATE_FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    frm_in_if.sink      frame,
    frm_out_if.source   result,
    frm_cfg_if.sink     cfg
);

    frm_pkg::ctrl_cmd_t cmd;
    frm_pkg::ctrl_sts_t sts;

    // register writes never stall; the user must send them only while the block is idle, the block does not enforce it
    assign cfg.ready = 1'b1;

    // sequencer: owns the input ready and the result valid
    frm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (frame.valid),
        .in_ready  (frame.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath: window counters, multiplier, divider, history ring, result register
    frm_datapath #(
        .HISTORY_DEPTH  (HISTORY_DEPTH),
        .RATE_FRAC_BITS (RATE_FRAC_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .frame_delta_us (frame.frame_delta_us),
        .cfg_we         (cfg.valid),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .current_rate   (result.current_rate),
        .min_rate       (result.min_rate),
        .max_rate       (result.max_rate),
        .mean_rate      (result.mean_rate)
    );

    // no new item while a division is still running
    `FRM_ASSERT_IMP(a_accept_div_idle, frame.valid && frame.ready, !sts.div_busy, "item taken during division")

    // the divider is only started when idle
    `FRM_ASSERT_IMP(a_start_div_idle, cmd.div_start, !sts.div_busy, "divider restarted while busy")

    // a result is loaded only into a free output register
    `FRM_ASSERT_IMP(a_load_slot_free, cmd.load_out, !result.valid || result.ready, "result overwritten")

    // a taken result is not shown again unless a new one was loaded
    `FRM_ASSERT_NXT(a_taken_clears, result.valid && result.ready && !cmd.load_out, !result.valid, "result repeated")

endmodule

>>> tb/frame_rate_meter_checker.sv
// checker of the frame rate meter: tracks register writes and frame items, predicts and compares results
module frame_rate_meter_checker #(
    parameter int HISTORY_DEPTH  = frm_pkg::HISTORY_DEPTH_DEF,
    parameter int RATE_FRAC_BITS = frm_pkg::RATE_FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    frm_in_if    frame,
    frm_out_if   result,
    frm_cfg_if   cfg,
    output int   mismatches,
    output int   pending,
    output int   windows_checked
);
    import frm_pkg::*;

    typedef struct packed {
        logic [RATE_W-1:0] current;
        logic [RATE_W-1:0] lowest;
        logic [RATE_W-1:0] highest;
        logic [RATE_W-1:0] average;
    } rate_set_t;

    rate_set_t rate_q[$];

    // predicted meter state
    logic [WIN_W-1:0]  win_len;
    logic [HCNT_W-1:0] hist_len;
    logic [CNT_W-1:0]  frame_cnt;
    logic [ACC_W-1:0]  elapsed;
    logic [RATE_W-1:0] hist_mem [HISTORY_DEPTH];
    int unsigned       held;
    int unsigned       slot;
    logic [63:0]       hist_sum;
    logic [RATE_W-1:0] low_rate;
    logic [RATE_W-1:0] high_rate;

    int err_cnt;
    int seen_cnt;

    function automatic logic [RATE_W-1:0] window_rate(input logic [CNT_W-1:0] frames,
                                                      input logic [ACC_W-1:0] span);
        logic [63:0] quo;
        if (span == '0)
            return RATE_MAX;
        quo = ((64'(frames) * 64'(US_PER_SECOND)) << RATE_FRAC_BITS) / 64'(span);
        return (quo > 64'(RATE_MAX)) ? RATE_MAX : quo[RATE_W-1:0];
    endfunction

    task automatic take_frame(input logic [DELTA_W-1:0] delta);
        logic [RATE_W-1:0] rate;
        int unsigned       lim;
        rate_set_t         want;
        if (frame_cnt != CNT_MAX)
            frame_cnt = frame_cnt + 1'b1;
        elapsed = elapsed + ACC_W'(delta);
        if (elapsed < ACC_W'(win_len))
            return;
        rate      = window_rate(frame_cnt, elapsed);
        frame_cnt = '0;
        elapsed   = '0;
        // ring holds at most the clamped history length, oldest dropped first
        if (hist_len == '0)
            lim = 1;
        else if (int'(hist_len) > HISTORY_DEPTH)
            lim = HISTORY_DEPTH;
        else
            lim = hist_len;
        while (held >= lim)
        begin
            hist_sum = hist_sum - hist_mem[(slot + HISTORY_DEPTH - held) % HISTORY_DEPTH];
            held--;
        end
        hist_mem[slot] = rate;
        hist_sum       = hist_sum + rate;
        held++;
        slot = (slot + 1) % HISTORY_DEPTH;
        if (rate < low_rate)
            low_rate = rate;
        if (rate > high_rate)
            high_rate = rate;
        want.current = rate;
        want.lowest  = low_rate;
        want.highest = high_rate;
        want.average = RATE_W'(hist_sum / held);
        rate_q.push_back(want);
    endtask

    task automatic check_field(input string name, input logic [RATE_W-1:0] want,
                               input logic [RATE_W-1:0] got);
        if (want !== got)
        begin
            err_cnt++;
            if (err_cnt <= 10)
                $display("mismatch in result %0d, %s: expected %0d, got %0d",
                         seen_cnt, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        rate_set_t want;
        if (!rst_n)
        begin
            rate_q.delete();
            win_len   = WIN_RESET;
            hist_len  = HCNT_RESET;
            frame_cnt = '0;
            elapsed   = '0;
            held      = 0;
            slot      = 0;
            hist_sum  = '0;
            low_rate  = RATE_MAX;
            high_rate = '0;
            err_cnt   = 0;
            seen_cnt  = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg_idx_t'(cfg.index))
                    CFG_WINDOW_US:
                        win_len = cfg.data[WIN_W-1:0];
                    CFG_HISTORY_COUNT:
                    begin
                        hist_len = cfg.data[HCNT_W-1:0];
                        held     = 0;
                        slot     = 0;
                        hist_sum = '0;
                    end
                    default: ;
                endcase
            end
            // results first, so an unexpected one is never matched by a fresh expectation
            if (result.valid && result.ready)
            begin
                if (rate_q.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected result: current %0d min %0d max %0d mean %0d",
                                 result.current_rate, result.min_rate,
                                 result.max_rate, result.mean_rate);
                end
                else
                begin
                    want = rate_q.pop_front();
                    check_field("current_rate", want.current, result.current_rate);
                    check_field("min_rate", want.lowest, result.min_rate);
                    check_field("max_rate", want.highest, result.max_rate);
                    check_field("mean_rate", want.average, result.mean_rate);
                    seen_cnt++;
                end
            end
            if (frame.valid && frame.ready)
                take_frame(frame.frame_delta_us);
        end
        mismatches      <= err_cnt;
        pending         <= rate_q.size();
        windows_checked <= seen_cnt;
    end

endmodule

>>> tb/tb.sv
// testbench top of the frame rate meter: clock, reset, stimulus, result pacing and verdict
module tb;
    import frm_pkg::*;

    localparam int LIMIT_CYCLES  = 2000000;
    localparam int SETTLE_CYCLES = 200;  // longer than a closing item takes to finish
    localparam int CHOKE_CYCLES  = 700;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 200;
    localparam int DELTA_TOP     = 2**DELTA_W - 1;
    localparam logic [WIN_W-1:0] WIN_TOP = '1;

    logic clk = 1'b0;
    logic rst_n;

    frm_in_if  frame ();
    frm_out_if result ();
    frm_cfg_if cfg ();

    int mismatches;
    int pending;
    int windows_checked;

    // pacing controls, written by the stimulus process with nonblocking assignments
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    int choke_ask = 0;

    int choke_given;
    int choke_left;
    int rx_left;
    int cycle_cnt = 0;
    int cur_win;
    int items_sent = 0;
    int writes_done = 0;

    always #2 clk = ~clk;

    frame_rate_meter DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame),
        .result (result),
        .cfg    (cfg)
    );

    frame_rate_meter_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .frame           (frame),
        .result          (result),
        .cfg             (cfg),
        .mismatches      (mismatches),
        .pending         (pending),
        .windows_checked (windows_checked)
    );

    // gap length: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 15);
        return $urandom_range(30, 120);
    endfunction

    // frame time shaped around the current window so that windows close often,
    // with some zeros, some full-range values and some exact window lengths
    function automatic logic [DELTA_W-1:0] pick_delta();
        int r;
        int reach;
        r = $urandom_range(0, 99);
        if (r < 6)
            return '0;
        if (r < 16)
            return DELTA_W'($urandom);
        if (r < 22)
            return DELTA_W'(cur_win);
        reach = 2 * (cur_win / int'($urandom_range(1, 6)));
        if (reach > DELTA_TOP)
            reach = DELTA_TOP;
        return DELTA_W'($urandom_range(0, reach));
    endfunction

    // called right after a rising edge; returns at the edge that takes the item,
    // leaving valid high so a back-to-back item needs no second assignment
    task automatic send_frame(input logic [DELTA_W-1:0] delta);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            frame.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frame.valid          <= 1'b1;
        frame.frame_delta_us <= delta;
        @(posedge clk);
        while (!frame.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        @(posedge clk);
        writes_done++;
    endtask

    task automatic set_window(input logic [WIN_W-1:0] w);
        write_reg(CFG_WINDOW_US, CFG_DATA_W'(w));
        cur_win = w;
    endtask

    // upper data bits are junk on purpose, only the low bits carry the count
    task automatic set_history(input logic [HCNT_W-1:0] h);
        logic [CFG_DATA_W-1:0] value;
        value             = CFG_DATA_W'($urandom);
        value[HCNT_W-1:0] = h;
        write_reg(CFG_HISTORY_COUNT, value);
    endtask

    // sender stops and waits for every outstanding result
    task automatic pause_until_drained();
        frame.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // block fully idle: no result owed and the last non-closing item finished
    task automatic wait_drained();
        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // result side: random ready with short and long holds, a steady mode,
    // and a long hold-off on request so the block fills and stalls its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result.ready <= 1'b0;
            rx_left      <= 0;
            choke_left   <= 0;
            choke_given  <= 0;
        end
        else if (choke_left != 0)
        begin
            choke_left   <= choke_left - 1;
            result.ready <= (choke_left == 1);
        end
        else if (choke_given != choke_ask)
        begin
            choke_given  <= choke_ask;
            choke_left   <= CHOKE_CYCLES;
            result.ready <= 1'b0;
        end
        else if (rx_left != 0)
            rx_left <= rx_left - 1;
        else if (rx_steady || !result.ready)
        begin
            result.ready <= 1'b1;
            rx_left      <= $urandom_range(0, 24);
        end
        else
        begin
            result.ready <= 1'b0;
            rx_left      <= pick_gap();
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES)
        begin
            $display("[frame_rate_meter] ERROR");
            $finish;
        end
    end

    initial
    begin
        frame.valid          <= 1'b0;
        frame.frame_delta_us <= '0;
        cfg.valid            <= 1'b0;
        cfg.index            <= CFG_WINDOW_US;
        cfg.data             <= '0;
        rst_n                <= 1'b0;
        cur_win = WIN_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: window 33333, 60 rates averaged
        send_frame('0);
        send_frame('0);
        send_frame(20'd33333);       // three frames close exactly at the window
        send_frame(20'd16666);
        send_frame(20'd16667);
        send_frame(20'(DELTA_TOP));  // longest frame, lowest rate
        send_frame(20'd1);
        send_frame(20'd33332);
        wait_drained();

        // window of zero: every frame closes; zero elapsed time saturates,
        // one microsecond overflows the rate; history count zero acts as one
        set_window('0);
        set_history('0);
        send_frame('0);
        send_frame(20'd1);
        send_frame(20'd3);
        send_frame(20'(DELTA_TOP));
        send_frame('0);
        wait_drained();

        // widest window, history count above the ring depth
        set_window(WIN_TOP);
        set_history('1);
        send_frame(20'(DELTA_TOP));
        send_frame(20'd524288);
        send_frame(20'd524287);
        send_frame('0);
        send_frame(20'(DELTA_TOP));
        send_frame(20'(DELTA_TOP));
        wait_drained();

        // narrowest window, full ring depth
        set_window(20'd1);
        set_history(7'd64);
        send_frame(20'd1);
        send_frame(20'd2);
        send_frame(20'd1000);
        send_frame('0);
        send_frame(20'd7);
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                1:
                begin
                    // short windows into a full ring while the result side chokes
                    set_window(WIN_W'($urandom_range(1, 300)));
                    set_history(7'd64);
                    choke_ask <= choke_ask + 1;
                end
                2:
                begin
                    set_window(WIN_TOP);
                    set_history(HCNT_W'($urandom_range(65, 127)));
                end
                4:
                begin
                    set_window('0);
                    set_history(HCNT_W'($urandom_range(1, 8)));
                end
                default:
                begin
                    if ($urandom_range(0, 9) < 7)
                        set_window(WIN_W'($urandom_range(1, 5000)));
                    else
                        set_window(WIN_W'($urandom_range(1, DELTA_TOP)));
                    // history survives a window change when left alone
                    if ($urandom_range(0, 9) < 7)
                        set_history(HCNT_W'($urandom_range(0, 127)));
                end
            endcase
            // one phase with no idling on either side
            tx_steady <= (ph == 3);
            rx_steady <= (ph == 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 5 && n == PHASE_ITEMS / 2)
                    pause_until_drained();
                send_frame(pick_delta());
            end
            wait_drained();
        end

        $display("run covered %0d frame items under %0d register writes", items_sent,
                 writes_done);
        $display("%0d closed windows checked, %0d mismatches", windows_checked, mismatches);
        if (mismatches == 0)
            $display("[frame_rate_meter] OK");
        else
            $display("[frame_rate_meter] ERROR");
        $finish;
    end

endmodule

>>> frame_rate_meter.f
+incdir+rtl
rtl/frm_pkg.sv
rtl/frm_if.sv
rtl/frm_divider.sv
rtl/frm_ctrl.sv
rtl/frm_datapath.sv
rtl/frame_rate_meter.sv
tb/frame_rate_meter_checker.sv
tb/tb.sv
